// ----- sv/first_fit_page_extent_allocator_core_defines.svh -----
// Assertion macros for the allocator core RTL.
`ifndef FIRST_FIT_PAGE_EXTENT_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_PAGE_EXTENT_ALLOCATOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FFPA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define FFPA_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m failed");
`else
`define FFPA_ASSERT(lbl, clk, rst_n, prop)
`define FFPA_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ----- sv/ffpa_pkg.sv -----
`default_nettype none
package ffpa_pkg;
    localparam int MAX_EXTENTS   = 16;
    localparam int PAGE_NUM_BITS = 40;
    localparam int COUNT_BITS    = 24;
    localparam int IDX_W         = $clog2(MAX_EXTENTS);
    localparam int CNT_W         = $clog2(MAX_EXTENTS + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MASK = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_ZERO_CNT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_MERGE,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        C_HOLD,
        C_FROM_LO,
        C_FROM_HI,
        C_LOAD
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic [PAGE_NUM_BITS-1:0] start;
        logic [COUNT_BITS-1:0]    len;
    } t_cell_ctl;

    typedef struct packed {
        logic fit;
        logic ge;
    } t_cell_stat;
endpackage
`default_nettype wire

// ----- sv/first_fit_page_extent_allocator_core.sv -----
// An allocate or a zero-count request goes from S_FIND to S_DONE. A free goes on to S_MERGE,
// which merges one following extent per step, then inserts the extent or reports full, then S_DONE.
// Throughput: one request at a time; the merge loop removes one extent per cycle.
// A new input beat is taken while the previous result waits on the output.
// Reset (synchronous, active low) empties the extent table and clears the output valid.
`default_nettype none
`include "first_fit_page_extent_allocator_core_defines.svh"
module first_fit_page_extent_allocator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // page_addr[39:0], page_count[63:40]
    input  wire logic        s_tuser,  // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata   // status[1:0], alloc_page[41:2], extents_used[46:42]
);
    localparam int MX = ffpa_pkg::MAX_EXTENTS;
    localparam int PB = ffpa_pkg::PAGE_NUM_BITS;
    localparam int CB = ffpa_pkg::COUNT_BITS;
    localparam int IW = ffpa_pkg::IDX_W;
    localparam int NW = ffpa_pkg::CNT_W;

    ffpa_pkg::t_state r_state, n_state;
    logic              r_cmd, n_cmd;
    logic [PB-1:0]     r_addr, n_addr;
    logic [CB-1:0]     r_cnt, n_cnt;
    logic [NW-1:0]     r_count, n_count;
    logic [NW-1:0]     r_p, n_p;
    logic [CB-1:0]     r_len, n_len;
    logic [PB:0]       r_end, n_end;
    logic              r_merged, n_merged;
    ffpa_pkg::t_status r_res_st, n_res_st;
    logic [PB-1:0]     r_res_pg, n_res_pg;
    logic              r_o_valid, n_o_valid;
    ffpa_pkg::t_status r_o_st, n_o_st;
    logic [PB-1:0]     r_o_pg, n_o_pg;
    logic [NW-1:0]     r_o_used, n_o_used;

    logic [PB-1:0]        c_start [MX];
    logic [CB-1:0]        c_len   [MX];
    ffpa_pkg::t_cell_stat c_stat  [MX];
    ffpa_pkg::t_cell_ctl  c_ctl   [MX];

    logic          fit_found;
    logic [IW-1:0] fit_idx;
    logic [NW-1:0] ge_idx;
    logic [CB-1:0] fit_newlen;
    logic [IW-1:0] p_idx;
    logic          p_in;
    logic [CB:0]   sum_len;
    logic          can_merge;

    genvar g;
    generate
        for (g = 0; g < MX; g++) begin : g_cell
            logic [PB-1:0] lo_s, hi_s;
            logic [CB-1:0] lo_l, hi_l;
            if (g == 0) begin : g_lo0
                assign lo_s = '0;
                assign lo_l = '0;
            end else begin : g_lo
                assign lo_s = c_start[g-1];
                assign lo_l = c_len[g-1];
            end
            if (g == MX - 1) begin : g_hit
                assign hi_s = '0;
                assign hi_l = '0;
            end else begin : g_hi
                assign hi_s = c_start[g+1];
                assign hi_l = c_len[g+1];
            end
            ffpa_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (c_ctl[g]),
                .i_lo_start (lo_s),
                .i_lo_len   (lo_l),
                .i_hi_start (hi_s),
                .i_hi_len   (hi_l),
                .i_addr     (r_addr),
                .i_cnt      (r_cnt),
                .o_start    (c_start[g]),
                .o_len      (c_len[g]),
                .o_stat     (c_stat[g])
            );
        end
    endgenerate

    always_comb begin
        fit_found = 1'b0;
        fit_idx   = '0;
        ge_idx    = r_count;
        for (int k = MX - 1; k >= 0; k--) begin
            if ((NW'(k) < r_count) && c_stat[k].fit) begin
                fit_found = 1'b1;
                fit_idx   = IW'(k);
            end
            if ((NW'(k) < r_count) && c_stat[k].ge) begin
                ge_idx = NW'(k);
            end
        end
    end

    assign fit_newlen = c_len[fit_idx] - r_cnt;
    assign p_in       = (r_p < r_count);
    assign p_idx      = r_p[IW-1:0];
    assign sum_len    = {1'b0, r_len} + {1'b0, c_len[p_idx]};
    assign can_merge  = p_in && ({1'b0, c_start[p_idx]} == r_end)
                        && (sum_len <= {1'b0, ffpa_pkg::COUNT_MASK});

    assign s_tready = (r_state == ffpa_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ffpa_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    n_state = ffpa_pkg::S_FIND;
                end
            end
            ffpa_pkg::S_FIND: begin
                if (r_cnt == '0 || !r_cmd) begin
                    n_state = ffpa_pkg::S_DONE;
                end else begin
                    n_state = ffpa_pkg::S_MERGE;
                end
            end
            ffpa_pkg::S_MERGE: begin
                if (!can_merge) begin
                    n_state = ffpa_pkg::S_DONE;
                end
            end
            ffpa_pkg::S_DONE: begin
                if (!r_o_valid || m_tready) begin
                    n_state = ffpa_pkg::S_IDLE;
                end
            end
            default: n_state = ffpa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd     = r_cmd;
        n_addr    = r_addr;
        n_cnt     = r_cnt;
        n_count   = r_count;
        n_p       = r_p;
        n_len     = r_len;
        n_end     = r_end;
        n_merged  = r_merged;
        n_res_st  = r_res_st;
        n_res_pg  = r_res_pg;
        n_o_valid = r_o_valid && !m_tready;
        n_o_st    = r_o_st;
        n_o_pg    = r_o_pg;
        n_o_used  = r_o_used;
        for (int k = 0; k < MX; k++) begin
            c_ctl[k] = '{op: ffpa_pkg::C_HOLD, start: '0, len: '0};
        end
        case (r_state)
            ffpa_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    n_cmd  = s_tuser;
                    n_addr = s_tdata[PB-1:0];
                    n_cnt  = s_tdata[PB+CB-1:PB];
                end
            end
            ffpa_pkg::S_FIND: begin
                n_res_pg = '0;
                if (r_cnt == '0) begin
                    n_res_st = ffpa_pkg::ST_ZERO_CNT;
                end else if (!r_cmd) begin
                    if (!fit_found) begin
                        n_res_st = ffpa_pkg::ST_NO_FIT;
                    end else begin
                        n_res_st = ffpa_pkg::ST_OK;
                        n_res_pg = c_start[fit_idx] + PB'(fit_newlen);
                        if (fit_newlen != '0) begin
                            c_ctl[fit_idx] = '{op: ffpa_pkg::C_LOAD,
                                               start: c_start[fit_idx], len: fit_newlen};
                        end else begin
                            for (int k = 0; k < MX; k++) begin
                                if (IW'(k) >= fit_idx) begin
                                    c_ctl[k].op = ffpa_pkg::C_FROM_HI;
                                end
                            end
                            n_count = r_count - NW'(1);
                        end
                    end
                end else begin
                    n_p      = ge_idx;
                    n_len    = r_cnt;
                    n_end    = {1'b0, r_addr} + (PB+1)'(r_cnt);
                    n_merged = 1'b0;
                end
            end
            ffpa_pkg::S_MERGE: begin
                if (can_merge) begin
                    for (int k = 0; k < MX; k++) begin
                        if (IW'(k) >= p_idx) begin
                            c_ctl[k].op = ffpa_pkg::C_FROM_HI;
                        end
                    end
                    n_count  = r_count - NW'(1);
                    n_len    = sum_len[CB-1:0];
                    n_end    = r_end + (PB+1)'(c_len[p_idx]);
                    n_merged = 1'b1;
                end else if (!r_merged && (r_count == NW'(MX))) begin
                    n_res_st = ffpa_pkg::ST_FULL;
                end else begin
                    for (int k = 0; k < MX; k++) begin
                        if (NW'(k) > r_p) begin
                            c_ctl[k].op = ffpa_pkg::C_FROM_LO;
                        end
                    end
                    c_ctl[p_idx] = '{op: ffpa_pkg::C_LOAD, start: r_addr, len: r_len};
                    n_count  = r_count + NW'(1);
                    n_res_st = ffpa_pkg::ST_OK;
                end
            end
            ffpa_pkg::S_DONE: begin
                if (!r_o_valid || m_tready) begin
                    n_o_valid = 1'b1;
                    n_o_st    = r_res_st;
                    n_o_pg    = r_res_pg;
                    n_o_used  = r_count;
                end
            end
            default: begin
                n_o_valid = r_o_valid && !m_tready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ffpa_pkg::S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_cmd    <= n_cmd;
        r_addr   <= n_addr;
        r_cnt    <= n_cnt;
        r_p      <= n_p;
        r_len    <= n_len;
        r_end    <= n_end;
        r_merged <= n_merged;
        r_res_st <= n_res_st;
        r_res_pg <= n_res_pg;
        r_o_st   <= n_o_st;
        r_o_pg   <= n_o_pg;
        r_o_used <= n_o_used;
    end

    assign m_tvalid = r_o_valid;
    assign m_tdata  = {1'b0, r_o_used, r_o_pg, r_o_st};

    `FFPA_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= NW'(MX))
    `FFPA_ASSERT(a_p_range, i_clk, i_rst_n, (r_state == ffpa_pkg::S_MERGE) |-> (r_p <= r_count))
    `FFPA_ASSERT_NEXT(a_accept_find, i_clk, i_rst_n, s_tvalid && s_tready,
        r_state == ffpa_pkg::S_FIND)
endmodule
`default_nettype wire

// ----- sv/ffpa_cell.sv -----
`default_nettype none
module ffpa_cell (
    input  wire logic                                  i_clk,
    input  wire ffpa_pkg::t_cell_ctl                   i_ctl,
    input  wire logic [ffpa_pkg::PAGE_NUM_BITS-1:0]    i_lo_start,
    input  wire logic [ffpa_pkg::COUNT_BITS-1:0]       i_lo_len,
    input  wire logic [ffpa_pkg::PAGE_NUM_BITS-1:0]    i_hi_start,
    input  wire logic [ffpa_pkg::COUNT_BITS-1:0]       i_hi_len,
    input  wire logic [ffpa_pkg::PAGE_NUM_BITS-1:0]    i_addr,
    input  wire logic [ffpa_pkg::COUNT_BITS-1:0]       i_cnt,
    output logic [ffpa_pkg::PAGE_NUM_BITS-1:0]         o_start,
    output logic [ffpa_pkg::COUNT_BITS-1:0]            o_len,
    output ffpa_pkg::t_cell_stat                       o_stat
);
    logic [ffpa_pkg::PAGE_NUM_BITS-1:0] r_start, n_start;
    logic [ffpa_pkg::COUNT_BITS-1:0]    r_len, n_len;

    always_comb begin
        n_start = r_start;
        n_len   = r_len;
        case (i_ctl.op)
            ffpa_pkg::C_FROM_LO: begin
                n_start = i_lo_start;
                n_len   = i_lo_len;
            end
            ffpa_pkg::C_FROM_HI: begin
                n_start = i_hi_start;
                n_len   = i_hi_len;
            end
            ffpa_pkg::C_LOAD: begin
                n_start = i_ctl.start;
                n_len   = i_ctl.len;
            end
            default: begin
                n_start = r_start;
                n_len   = r_len;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_len   <= n_len;
    end

    assign o_start    = r_start;
    assign o_len      = r_len;
    assign o_stat.fit = (r_len >= i_cnt);
    assign o_stat.ge  = (r_start >= i_addr);
endmodule
`default_nettype wire

// ----- tb/tb_first_fit_page_extent_allocator_core.sv -----
`default_nettype none
module tb_first_fit_page_extent_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MX = ffpa_pkg::MAX_EXTENTS;
    localparam int PB = ffpa_pkg::PAGE_NUM_BITS;
    localparam int CB = ffpa_pkg::COUNT_BITS;

    typedef struct {
        ffpa_pkg::t_status status;
        logic [PB-1:0]     page;
        logic [4:0]        used;
    } t_alloc_reply;

    class extent_scoreboard;
        logic [PB-1:0] ext_start[MX];
        logic [CB-1:0] ext_len[MX];
        int            ext_cnt;
        t_alloc_reply  pending[$];
        int            errors;

        function new();
            ext_cnt = 0;
            errors = 0;
        endfunction

        function ffpa_pkg::t_status carve(logic [CB-1:0] cnt, output logic [PB-1:0] pg);
            int i;
            i = 0;
            pg = '0;
            while (i < ext_cnt && ext_len[i] < cnt) i++;
            if (i >= ext_cnt) return ffpa_pkg::ST_NO_FIT;
            ext_len[i] = ext_len[i] - cnt;
            pg = ext_start[i] + PB'(ext_len[i]);
            if (ext_len[i] == 0) begin
                for (int k = i; k < ext_cnt - 1; k++) begin
                    ext_start[k] = ext_start[k+1];
                    ext_len[k] = ext_len[k+1];
                end
                ext_cnt--;
            end
            return ffpa_pkg::ST_OK;
        endfunction

        function ffpa_pkg::t_status give_back(logic [PB-1:0] addr, logic [CB-1:0] cnt);
            int p, j, m;
            logic [63:0] len, fin;
            logic [PB-1:0] ts[MX];
            logic [CB-1:0] tl[MX];
            p = 0;
            len = 64'(cnt);
            fin = 64'(addr) + 64'(cnt);
            while (p < ext_cnt && ext_start[p] < addr) p++;
            j = p;
            while (j < ext_cnt && 64'(ext_start[j]) == fin
                   && len + 64'(ext_len[j]) <= 64'(ffpa_pkg::COUNT_MASK)) begin
                len += 64'(ext_len[j]);
                fin += 64'(ext_len[j]);
                j++;
            end
            m = j - p;
            if (m == 0 && ext_cnt >= MX) return ffpa_pkg::ST_FULL;
            ts = ext_start;
            tl = ext_len;
            if (m == 0) begin
                for (int k = ext_cnt; k > p; k--) begin
                    ext_start[k] = ts[k-1];
                    ext_len[k] = tl[k-1];
                end
                ext_cnt++;
            end else begin
                for (int k = j; k < ext_cnt; k++) begin
                    ext_start[p+1+k-j] = ts[k];
                    ext_len[p+1+k-j] = tl[k];
                end
                ext_cnt = ext_cnt + 1 - m;
            end
            ext_start[p] = addr;
            ext_len[p] = len[CB-1:0];
            return ffpa_pkg::ST_OK;
        endfunction

        function void note_request(logic is_free, logic [PB-1:0] addr, logic [CB-1:0] cnt);
            t_alloc_reply r;
            logic [PB-1:0] pg;
            pg = '0;
            if (cnt == 0) r.status = ffpa_pkg::ST_ZERO_CNT;
            else if (!is_free) r.status = carve(cnt, pg);
            else r.status = give_back(addr, cnt);
            r.page = (r.status == ffpa_pkg::ST_OK) ? pg : '0;
            r.used = 5'(ext_cnt);
            pending.push_back(r);
        endfunction

        function void check_reply(logic [47:0] d);
            t_alloc_reply e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h", $realtime, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[1:0] != e.status) begin
                $display("%0t: status expected %0d actual %0d", $realtime, e.status, d[1:0]);
                errors++;
            end
            if (d[41:2] != e.page) begin
                $display("%0t: alloc_page expected %h actual %h", $realtime, e.page, d[41:2]);
                errors++;
            end
            if (d[46:42] != e.used) begin
                $display("%0t: extents_used expected %0d actual %0d", $realtime, e.used,
                         d[46:42]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;

    extent_scoreboard sb = new();
    int send_idle_pct = 19;
    int recv_idle_pct = 78;
    int cycles = 0;
    localparam int CYCLE_LIMIT = 400000;

    first_fit_page_extent_allocator_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (i_rst_n) begin
            if (m_tvalid && m_tready) sb.check_reply(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(logic is_free, logic [PB-1:0] addr, logic [CB-1:0] cnt);
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        s_tvalid <= 1;
        s_tuser <= is_free;
        s_tdata <= {cnt, addr};
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(is_free, addr, cnt);
        s_tvalid <= 0;
        s_tdata <= {$urandom, $urandom};
        s_tuser <= 1'($urandom_range(1));
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        logic [PB-1:0] base;
        logic [CB-1:0] c;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            base = 40'h100 * $urandom_range(40);
            c = 24'($urandom_range(1, 64));
            if (k < 40) send_request(1, base + 40'($urandom_range(0, 3) * 64), c);
            else if (k < 80) send_request(0, 40'({$urandom, $urandom}),
                                          24'($urandom_range(1, 100)));
            else if (k < 88) send_request(1'($urandom_range(1)), 40'({$urandom, $urandom}),
                                          24'($urandom));
            else if (k < 94) send_request(1'($urandom_range(1)), 40'({$urandom, $urandom}),
                                          '0);
            else send_request(1, 40'({$urandom, $urandom}), 24'($urandom_range(1, 200)));
            if (i == n / 2) drain();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_request(0, '0, 1);
        send_request(1, '0, 0);
        send_request(0, '1, 0);
        send_request(1, 40'h1000, 24'hFFFFFF);
        send_request(0, '1, 24'hFFFFFF);
        send_request(1, 40'h2000, 16);
        send_request(1, 40'h1FF0, 16);
        send_request(1, 40'h1FE0, 8);
        send_request(0, '0, 4);
        send_request(1, 40'h3000, 24'hFFFFF0);
        send_request(1, 40'h2FFF, 1);
        send_request(1, 40'hFFFFFFFFFF, 24'hFFFFFF);
        send_request(1, 40'h2008, 4);
        for (int i = 0; i < 13; i++) send_request(1, 40'h10000 + 40'(i) * 40'h100, 8);
        send_request(1, 40'h10F00, 8);
        send_request(1, 40'h10FF8, 8);
        send_request(0, '0, 24'hFFFFFF);
        drain();
        for (int i = 0; i < 40; i++) send_request(0, '0, 24'($urandom_range(1, 8)));
        drain();
        random_phase(200);
        drain();
        send_idle_pct = 78;
        recv_idle_pct = 19;
        random_phase(200);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(200);
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
